// ----- hdl/rrd_pkg.sv -----
// Package: constants, codes and types shared by the range reply decoder.
`default_nettype none
package rrd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned DIST_W = 29;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned CIDX_W = 1;

  localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] ASCII_E    = 8'h45;

  localparam logic [POS_W-1:0] LAST_POS_COARSE = 4'd10;
  localparam logic [POS_W-1:0] LAST_POS_FINE   = 4'd11;
  localparam logic [POS_W-1:0] POS_FIRST       = 4'd0;
  localparam logic [POS_W-1:0] POS_ERR_MARK    = 4'd3;
  localparam logic [POS_W-1:0] POS_INT_LAST    = 4'd5;
  localparam logic [POS_W-1:0] POS_FRAC_FIRST  = 4'd7;

  localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ADDR    = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DEV_ERR = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_DEVICE_ADDRESS  = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_FINE_RESOLUTION = 1'd1;

  localparam logic [BYTE_W-1:0] DEVICE_ADDRESS_RST = 8'd128;

  typedef struct packed {
    logic                     last;
    logic [STAT_W-1:0]        status;
    logic signed [DIST_W-1:0] distance;
  } rrd_result_t;

endpackage
`default_nettype wire

// ----- hdl/rrd_core.sv -----
// Frame state and byte decode: position, digit accumulate, flags, result.
`default_nettype none
module rrd_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      advance,
  input  wire logic [rrd_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic                      frame_start,
  input  wire logic [rrd_pkg::BYTE_W-1:0] device_address,
  input  wire logic                      fine_resolution,
  output rrd_pkg::rrd_result_t           result
);
  import rrd_pkg::*;

  logic [POS_W-1:0]  byte_position_r, byte_position_nxt;
  logic [DIST_W-1:0] acc_r, acc_nxt;
  logic              address_bad_r, address_bad_nxt;
  logic              error_seen_r, error_seen_nxt;

  logic [POS_W-1:0]  pos;
  logic              first;
  logic              addr_bad_cur;
  logic              err_cur;
  logic [DIST_W-1:0] acc_cur;
  logic [DIST_W-1:0] acc_x10;
  logic [DIST_W-1:0] digit;
  logic [BYTE_W:0]   digit_raw;
  logic [POS_W-1:0]  last_pos;
  logic              is_digit;

  always_comb begin
    pos          = frame_start ? POS_FIRST : byte_position_r;
    first        = (pos == POS_FIRST);
    addr_bad_cur = first ? (rx_byte != device_address) : address_bad_r;
    err_cur      = first ? 1'b0 : error_seen_r;
    acc_cur      = first ? '0 : acc_r;
    acc_x10      = (acc_cur << 3) + (acc_cur << 1);
    digit_raw    = {1'b0, rx_byte} - {1'b0, ASCII_ZERO};
    digit        = {{(DIST_W-BYTE_W-1){digit_raw[BYTE_W]}}, digit_raw};
    last_pos     = fine_resolution ? LAST_POS_FINE : LAST_POS_COARSE;
    is_digit     = ((pos >= POS_ERR_MARK) && (pos <= POS_INT_LAST)) || (pos >= POS_FRAC_FIRST);

    result.last = (pos >= last_pos);
    if (addr_bad_cur) begin
      result.status   = STAT_ADDR;
      result.distance = '0;
    end else if (err_cur) begin
      result.status   = STAT_DEV_ERR;
      result.distance = '0;
    end else begin
      result.status   = STAT_OK;
      result.distance = fine_resolution ? acc_cur : acc_x10;
    end

    address_bad_nxt   = addr_bad_cur;
    error_seen_nxt    = err_cur;
    acc_nxt           = acc_cur;
    byte_position_nxt = POS_FIRST;
    if (!result.last) begin
      if ((pos == POS_ERR_MARK) && (rx_byte == ASCII_E)) begin
        error_seen_nxt = 1'b1;
      end
      if (is_digit) begin
        acc_nxt = acc_x10 + digit;
      end
      byte_position_nxt = pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_position_r <= '0;
      acc_r           <= '0;
      address_bad_r   <= 1'b0;
      error_seen_r    <= 1'b0;
    end else if (advance) begin
      byte_position_r <= byte_position_nxt;
      acc_r           <= acc_nxt;
      address_bad_r   <= address_bad_nxt;
      error_seen_r    <= error_seen_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/range_reply_decoder.sv -----
// Top level: config registers, input register, decode core and result register.
//
//  channel | ports                                        | direction
//  in      | in_valid, in_ready, in_rx_byte, in_frame_start | receive
//  out     | out_valid, out_ready, out_status, out_distance_tenth_mm | send
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data    | receive
//
// One byte a cycle unless stalled: input register, decode core, result register.
// The multiply-by-ten accumulate between the input and result registers sets the pace.
// Reset clears frame state; the first byte after reset is byte 0 of a frame.
// A held result stalls the byte that ends the next frame once it reaches the core;
// input then stops until the held result leaves.
`default_nettype none
module range_reply_decoder (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [rrd_pkg::BYTE_W-1:0]        in_rx_byte,
  input  wire logic                              in_frame_start,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [rrd_pkg::STAT_W-1:0]             out_status,
  output logic signed [rrd_pkg::DIST_W-1:0]      out_distance_tenth_mm,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rrd_pkg::CIDX_W-1:0]        cfg_index,
  input  wire logic [rrd_pkg::BYTE_W-1:0]        cfg_data
);
  import rrd_pkg::*;

  logic [BYTE_W-1:0] device_address_r;
  logic              fine_resolution_r;

  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_start_r;
  logic              s1_adv;

  logic                     out_valid_r;
  logic [STAT_W-1:0]        out_status_r;
  logic signed [DIST_W-1:0] out_dist_r;

  rrd_result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r  <= DEVICE_ADDRESS_RST;
      fine_resolution_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEVICE_ADDRESS:  device_address_r  <= cfg_data;
        CFG_FINE_RESOLUTION: fine_resolution_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s1_adv   = s1_valid_r && (!res.last || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
    end
  end

  rrd_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .advance         (s1_adv),
    .rx_byte         (s1_byte_r),
    .frame_start     (s1_start_r),
    .device_address  (device_address_r),
    .fine_resolution (fine_resolution_r),
    .result          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res.last) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res.last) begin
      out_status_r <= res.status;
      out_dist_r   <= res.distance;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_distance_tenth_mm = out_dist_r;

endmodule
`default_nettype wire
